/* design/pab_pkg.sv */
// ----------------------------------------------------------------------------
// pab_pkg
// Shared types and constants for the two-bank stereo sample buffer.
// ----------------------------------------------------------------------------
package pab_pkg;

   // Frames per bank and bank count
   localparam int MAX_FRAMES = 8192;
   localparam int BANKS      = 2;

   // Derived widths
   localparam int FRAME_W  = $clog2(MAX_FRAMES);          // frame index in a bank
   localparam int BANK_W   = $clog2(BANKS);               // bank select
   localparam int ADDR_W   = BANK_W + FRAME_W;            // sample store address
   localparam int BLOCK_W  = FRAME_W + 1;                 // block size, read position
   localparam int SAMPLE_W = 16;
   localparam int WORD_W   = 2 * SAMPLE_W;                // one stereo frame
   localparam int DROP_W   = 32;

   localparam logic [BLOCK_W-1:0] BLOCK_RESET = BLOCK_W'(512);

   // Operation codes carried on req_tuser
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_CLAIM = 2'd1,
      OP_READ  = 2'd2,
      OP_DRAIN = 2'd3
   } op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ
   } state_type;

   // One request word, unpacked
   typedef struct packed {
      op_type                      op;
      logic [FRAME_W-1:0]          frame_index;
      logic signed [SAMPLE_W-1:0]  left_in;
      logic signed [SAMPLE_W-1:0]  right_in;
      logic                        suppress_drop;
   } item_type;

   // One response word, unpacked
   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  left_out;
      logic signed [SAMPLE_W-1:0]  right_out;
      logic [DROP_W-1:0]           drop_count;
      logic                        request_flag;
      logic                        claim_error;
   } result_type;

   // Sample store access from the controller
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [WORD_W-1:0]  wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } ram_cmd_type;

endpackage

/* design/pab_sample_ram.sv */
// ----------------------------------------------------------------------------
// pab_sample_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pab_sample_ram #(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 14
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pab_ctrl.sv */
// ----------------------------------------------------------------------------
// pab_ctrl
// Bank, read position, request and drop bookkeeping; drives the sample
// store and sweeps the whole store to zero on reset and a bank on underrun.
// ----------------------------------------------------------------------------
module pab_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   // request word
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pab_pkg::item_type         item,
   // block size register write
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [pab_pkg::BLOCK_W-1:0] csr_data,
   // result toward the output register
   input  logic                      out_free,
   output logic                      res_valid,
   output pab_pkg::result_type       res,
   // sample store
   output pab_pkg::ram_cmd_type      ram_cmd,
   input  logic [pab_pkg::WORD_W-1:0] ram_rdata
);
   import pab_pkg::*;

   state_type           state_ff, state_in;
   logic [BLOCK_W-1:0]  frames_cfg_ff, frames_cfg_in;
   logic [BANK_W-1:0]   front_ff, front_in;
   logic                pend_ff, pend_in;
   logic [DROP_W-1:0]   drops_ff, drops_in;
   logic [BLOCK_W-1:0]  rpos_ff, rpos_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]   clr_last_ff, clr_last_in;

   logic [BLOCK_W-1:0]  eff;
   logic [BLOCK_W-1:0]  eff_m1;
   logic                accept;
   logic                swap;
   logic [BANK_W-1:0]   back;
   logic [BANK_W-1:0]   rd_bank;
   logic [FRAME_W-1:0]  rd_frame;

   // effective block size: zero acts as one, clamp at bank size
   always_comb begin
      if (frames_cfg_ff == '0) begin
         eff = BLOCK_W'(1);
      end else if (frames_cfg_ff > BLOCK_W'(MAX_FRAMES)) begin
         eff = BLOCK_W'(MAX_FRAMES);
      end else begin
         eff = frames_cfg_ff;
      end
   end

   assign eff_m1    = eff - BLOCK_W'(1);
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign swap      = (rpos_ff >= eff);
   assign back      = front_ff + BANK_W'(1);
   assign rd_bank   = swap ? back : front_ff;
   assign rd_frame  = swap ? '0 : rpos_ff[FRAME_W-1:0];

   // register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         frames_cfg_ff <= BLOCK_RESET;
         front_ff      <= '0;
         pend_ff       <= 1'b1;
         drops_ff      <= '0;
         rpos_ff       <= '0;
         clr_addr_ff   <= '0;
         clr_last_ff   <= '1;
      end else begin
         state_ff      <= state_in;
         frames_cfg_ff <= frames_cfg_in;
         front_ff      <= front_in;
         pend_ff       <= pend_in;
         drops_ff      <= drops_in;
         rpos_ff       <= rpos_in;
         clr_addr_ff   <= clr_addr_in;
         clr_last_ff   <= clr_last_in;
      end
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      frames_cfg_in = csr_valid ? csr_data : frames_cfg_ff;
      front_in      = front_ff;
      pend_in       = pend_ff;
      drops_in      = drops_ff;
      rpos_in       = rpos_ff;
      clr_addr_in   = clr_addr_ff;
      clr_last_in   = clr_last_ff;

      res_valid        = 1'b0;
      res              = '0;
      res.request_flag = pend_ff;

      ram_cmd          = '0;

      unique case (state_ff)
         // zero fill, one entry per cycle
         ST_SWEEP: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = clr_addr_ff;
            clr_addr_in     = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == clr_last_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               unique case (item.op)
                  OP_WRITE: begin
                     res_valid = 1'b1;
                     if ({1'b0, item.frame_index} < eff) begin
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = {back, item.frame_index};
                        ram_cmd.wr_data = {item.right_in, item.left_in};
                     end
                  end

                  OP_CLAIM: begin
                     res_valid        = 1'b1;
                     pend_in          = 1'b0;
                     res.request_flag = 1'b0;
                     res.claim_error  = ~pend_ff;
                  end

                  OP_READ: begin
                     if (swap && pend_ff) begin
                        // underrun: new front bank reads as zero, then sweep it
                        res_valid   = 1'b1;
                        front_in    = back;
                        rpos_in     = BLOCK_W'(1);
                        if (!item.suppress_drop) begin
                           drops_in = drops_ff + DROP_W'(1);
                        end
                        clr_addr_in = {back, {FRAME_W{1'b0}}};
                        clr_last_in = {back, eff_m1[FRAME_W-1:0]};
                        state_in    = ST_SWEEP;
                     end else begin
                        if (swap) begin
                           front_in = back;
                           pend_in  = 1'b1;
                        end
                        rpos_in         = {1'b0, rd_frame} + BLOCK_W'(1);
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = {rd_bank, rd_frame};
                        state_in        = ST_READ;
                     end
                  end

                  OP_DRAIN: begin
                     res_valid      = 1'b1;
                     res.drop_count = drops_ff;
                     drops_in       = '0;
                  end

                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end

         // read data arrives from the store
         ST_READ: begin
            res_valid     = 1'b1;
            res.left_out  = ram_rdata[SAMPLE_W-1:0];
            res.right_out = ram_rdata[WORD_W-1:SAMPLE_W];
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/pingpong_audio_buffer_underrun.sv */
// ----------------------------------------------------------------------------
// pingpong_audio_buffer_underrun
// Two-bank stereo sample buffer with claim handshake and underrun counting.
// ----------------------------------------------------------------------------
// After reset the block zero-fills its 16384-entry sample store, one entry
// per cycle, and accepts no request word until that fill is done (block size
// writes are taken throughout). A frame read goes through the registered
// read port of the sample store. A read that swaps banks without a prior
// claim returns zero and then zero-fills the new front bank up to the
// effective block size (zero counts as one, capped at 8192), one entry per
// cycle, holding off the next word until that fill is done. A finished
// response sits in an output register, and the next word is taken as soon
// as that register is free or is being emptied.
module pingpong_audio_buffer_underrun (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // frame_index[12:0], left_in[28:13], right_in[44:29],
                                    // suppress_drop[45], zero[47:46]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // block size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [13:0] csr_data,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // left_out[15:0], right_out[31:16], drop_count[63:32],
                                    // request_flag[64], claim_error[65], zero[71:66]
);
   import pab_pkg::*;

   item_type           item;
   result_type         res;
   logic               res_valid;
   logic               out_free;
   ram_cmd_type        ram_cmd;
   logic [WORD_W-1:0]  ram_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   // unpack request word
   assign item.op            = op_type'(req_tuser);
   assign item.frame_index   = req_tdata[12:0];
   assign item.left_in       = req_tdata[28:13];
   assign item.right_in      = req_tdata[44:29];
   assign item.suppress_drop = req_tdata[45];

   pab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .item      (item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata)
   );

   pab_sample_ram #(
      .DATA_W (WORD_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rdata)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_data_ff.claim_error,
                        rsp_data_ff.request_flag,
                        rsp_data_ff.drop_count,
                        rsp_data_ff.right_out,
                        rsp_data_ff.left_out};

   // a response is only produced when the output register can take it
   a_res_fits: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("response produced while output register full");

   // the store is being zero-filled right after reset
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request taken during reset fill");

   // a failed claim leaves no request pending
   a_claim_err_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65]) |-> !rsp_tdata[64])
      else $error("claim error with request still pending");

endmodule
